[rtl/intel_hex_record_word_extractor_top_defines.svh]
// ----------------------------------------------------------------------------
// Intel HEX word extractor assertion macros
// Concurrent assertion forms used by the RTL parser.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_WORD_EXTRACTOR_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_WORD_EXTRACTOR_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define IHEX_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define IHEX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// Intel HEX word extractor package
// Widths, record layout constants, entry kinds and the character decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int RING_DEPTH = 64;
    localparam int SLOT_REG_W = $clog2(RING_DEPTH);
    localparam int SLOT_OUT_W = 6;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
    localparam logic [POS_W-1:0] DATA_START = 10'd9;
    localparam logic [POS_W-1:0] REC_END_MAX = 10'd519;
    localparam logic [1:0]       PHASE_MASK = 2'b11;
    localparam logic [7:0]       RECORD_MARK = 8'h3A;

    localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_3   = 10'd3;
    localparam logic [POS_W-1:0] POS_ADDR_2   = 10'd4;
    localparam logic [POS_W-1:0] POS_ADDR_1   = 10'd5;
    localparam logic [POS_W-1:0] POS_ADDR_0   = 10'd6;

    localparam logic [1:0] PHASE_LO_HI = 2'd1;
    localparam logic [1:0] PHASE_LO_LO = 2'd2;
    localparam logic [1:0] PHASE_HI_HI = 2'd3;
    localparam logic [1:0] PHASE_HI_LO = 2'd0;

    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_ADDR  = 2'd1,
        KIND_WORD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [15:0]           value;
        kind_t                 kind;
        logic [15:0]           words_seen;
    } result_t;

    // Upper-case hex digits only; everything else decodes as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_REG_W-1:0] ws);
        logic [SLOT_REG_W+SLOT_OUT_W-1:0] ext;
        ext = {{SLOT_OUT_W{1'b0}}, ws};
        return ext[SLOT_OUT_W-1:0];
    endfunction

endpackage

[rtl/ihex_in_stage.sv]
// ----------------------------------------------------------------------------
// Intel HEX input register
// Captures one received character per transfer and holds it for the parser.
// ----------------------------------------------------------------------------
module ihex_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    input  logic       consume,
    output logic       item_valid,
    output logic [7:0] item_char
);
    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       load;

    assign s_ready = !valid_reg || consume;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= s_rx_char;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;
endmodule

[rtl/ihex_parse.sv]
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Tracks the record position and partial values and forms ring entries.
// ----------------------------------------------------------------------------
`include "intel_hex_record_word_extractor_top_defines.svh"

module ihex_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  logic [7:0]        item_char,
    input  logic              out_free,
    output logic              step,
    output logic              emit_load,
    output ihex_pkg::result_t result
);
    import ihex_pkg::*;

    logic [POS_W-1:0]      position_reg, position_next;
    logic [POS_W-1:0]      record_end_reg, record_end_next;
    logic [15:0]           accum_reg, accum_next;
    logic [15:0]           high_part_reg, high_part_next;
    logic [SLOT_REG_W-1:0] write_slot_reg, write_slot_next;
    logic [15:0]           word_count_reg, word_count_next;

    logic [POS_W-1:0] pos;
    logic [3:0]       nib;
    logic [15:0]      sum;
    logic [15:0]      high_word;
    logic             emit;
    kind_t            kind;

    assign nib = nibble_of(item_char);
    assign pos = (item_char == RECORD_MARK) ? '0 : position_reg;

    always_comb begin
        accum_next      = accum_reg;
        record_end_next = record_end_reg;
        high_part_next  = high_part_reg;
        word_count_next = word_count_reg;
        emit            = 1'b0;
        kind            = KIND_COUNT;
        sum             = accum_reg + {12'h000, nib};
        high_word       = high_part_reg + {12'h000, nib};

        case (pos)
            POS_COUNT_HI: begin
                accum_next = {8'h00, nib, 4'h0};
            end
            POS_COUNT_LO: begin
                accum_next      = sum;
                record_end_next = DATA_START + {sum[8:0], 1'b0};
                emit            = 1'b1;
                kind            = KIND_COUNT;
            end
            POS_ADDR_3: begin
                accum_next = {8'h00, nib, 4'h0};
            end
            POS_ADDR_2: begin
                accum_next = {sum[7:0], 8'h00};
            end
            POS_ADDR_1: begin
                accum_next = accum_reg + {8'h00, nib, 4'h0};
            end
            POS_ADDR_0: begin
                accum_next = sum;
                emit       = 1'b1;
                kind       = KIND_ADDR;
            end
            default: begin
            end
        endcase

        if (pos >= DATA_START && pos < record_end_reg) begin
            case (pos[1:0] & PHASE_MASK)
                PHASE_LO_HI: begin
                    accum_next = {8'h00, nib, 4'h0};
                end
                PHASE_LO_LO: begin
                    accum_next = sum;
                end
                PHASE_HI_HI: begin
                    high_part_next = {8'h00, nib, 4'h0};
                end
                default: begin
                    // high byte completes the little-endian word
                    high_part_next  = {high_word[7:0], 8'h00};
                    accum_next      = accum_reg + {high_word[7:0], 8'h00};
                    word_count_next = word_count_reg + 16'd1;
                    emit            = 1'b1;
                    kind            = KIND_WORD;
                end
            endcase
        end

        position_next = (pos < POS_MAX) ? pos + POS_COUNT_HI : pos;

        write_slot_next = write_slot_reg;
        if (emit) begin
            if (write_slot_reg == SLOT_REG_W'(RING_DEPTH - 1)) begin
                write_slot_next = '0;
            end else begin
                write_slot_next = write_slot_reg + {{(SLOT_REG_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // A character that yields no entry retires even while the output is stalled
    assign step      = item_valid && (!emit || out_free);
    assign emit_load = step && emit;

    assign result.slot       = slot_out(write_slot_reg);
    assign result.value      = accum_next;
    assign result.kind       = kind;
    assign result.words_seen = word_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            record_end_reg <= '0;
            accum_reg      <= '0;
            high_part_reg  <= '0;
            write_slot_reg <= '0;
            word_count_reg <= '0;
        end else if (step) begin
            position_reg   <= position_next;
            record_end_reg <= record_end_next;
            accum_reg      <= accum_next;
            high_part_reg  <= high_part_next;
            write_slot_reg <= write_slot_next;
            word_count_reg <= word_count_next;
        end
    end

    `IHEX_ASSERT_NOW(a_rec_end_range, aclk, aresetn, record_end_reg <= REC_END_MAX, "record end out of range")
    `IHEX_ASSERT_NOW(a_slot_range, aclk, aresetn, write_slot_reg <= SLOT_REG_W'(RING_DEPTH - 1), "write slot beyond ring")
    `IHEX_ASSERT_NEXT(a_word_count, aclk, aresetn, aresetn && emit_load && kind == KIND_WORD, word_count_reg == $past(word_count_reg) + 16'd1, "word count not advanced on data word")
    `IHEX_ASSERT_NEXT(a_slot_hold, aclk, aresetn, aresetn && step && !emit, write_slot_reg == $past(write_slot_reg), "slot advanced without an entry")
endmodule

[rtl/ihex_out_stage.sv]
// ----------------------------------------------------------------------------
// Intel HEX result register
// Holds one ring entry until the downstream transfer completes.
// ----------------------------------------------------------------------------
module ihex_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  ihex_pkg::result_t      result,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [5:0]             m_slot,
    output logic [15:0]            m_value,
    output logic [1:0]             m_kind,
    output logic [15:0]            m_words_seen
);
    import ihex_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid      = valid_reg;
    assign m_slot       = data_reg.slot;
    assign m_value      = data_reg.value;
    assign m_kind       = data_reg.kind;
    assign m_words_seen = data_reg.words_seen;
endmodule

[rtl/intel_hex_record_word_extractor_top.sv]
// ----------------------------------------------------------------------------
// Intel HEX record word extractor
// Parses an Intel HEX character stream into byte count, address and word
// entries for a ring buffer.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle unless a character that
// produces an entry waits for space in the result register. A character
// sits in the input register while the parser updates its record state,
// and its entry, if any, loads into the result register as the parser
// steps. The rate of one character per cycle is set by the parser's state
// update, which is combinational. Characters that produce no entry are
// retired even while the result register waits for m_ready; only a
// character that produces an entry waits for space there.
// ----------------------------------------------------------------------------
module intel_hex_record_word_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_slot,
    output logic [15:0] m_value,
    output logic [1:0]  m_kind,
    output logic [15:0] m_words_seen
);
    import ihex_pkg::*;

    logic       item_valid;
    logic [7:0] item_char;
    logic       step;
    logic       emit_load;
    logic       out_free;
    result_t    result;

    ihex_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_char  (s_rx_char),
        .consume    (step),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    ihex_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_char  (item_char),
        .out_free   (out_free),
        .step       (step),
        .emit_load  (emit_load),
        .result     (result)
    );

    ihex_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (emit_load),
        .result       (result),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_value      (m_value),
        .m_kind       (m_kind),
        .m_words_seen (m_words_seen)
    );
endmodule

[tb/tb_intel_hex_record_word_extractor_top.sv]
// ----------------------------------------------------------------------------
// Intel HEX record word extractor testbench
// Feeds a directed table of characters and then random HEX records, with
// noise, truncated records, lower-case digits and one over-long line.
// Every result is checked, field by field, against the table's entries or
// those that a behavioural copy of the parser works out from the characters.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_word_extractor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int ITEMS         = 1800;
    localparam int FILLER_LEN    = 1100;
    localparam int IDLE_PCT      = 18;
    localparam int CALM_FROM     = 1200;
    localparam int CALM_TO       = 2200;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int REPORT_MAX    = 10;
    localparam int SCRIPT_LEN    = 25;

    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        result_t    res;
    } hex_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_char = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_slot;
    logic [15:0] m_value;
    logic [1:0]  m_kind;
    logic [15:0] m_words_seen;

    intel_hex_record_word_extractor_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_char    (s_rx_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_value      (m_value),
        .m_kind       (m_kind),
        .m_words_seen (m_words_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hex_char_t char_q[$];
    result_t   entry_q[$];
    hex_char_t on_wire;
    hex_char_t script [SCRIPT_LEN];

    // Parser state as seen from outside
    logic [POS_W-1:0] rec_pos = '0;
    logic [POS_W-1:0] rec_limit = '0;
    logic [15:0]      part_val = '0;
    logic [15:0]      part_high = '0;
    logic [5:0]       ring_slot = '0;
    logic [15:0]      word_total = '0;

    int cycle_no = 0;
    int faults = 0;
    int filler = 0;
    int chars_sent = 0;
    int records_sent = 0;
    int kind_seen [3] = '{0, 0, 0};

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - CH_ZERO);
        end else if (c >= "A" && c <= "F") begin
            return 4'(c - CH_UPPER_A + 8'd10);
        end
        return 4'h0;
    endfunction

    function automatic result_t take_slot(input kind_t k);
        result_t r;
        r.slot       = ring_slot;
        r.value      = part_val;
        r.kind       = k;
        r.words_seen = word_total;
        ring_slot    = (ring_slot == 6'(RING_DEPTH - 1)) ? 6'd0 : ring_slot + 6'd1;
        return r;
    endfunction

    // Advance the parser by one character; return 1 when it writes an entry
    function automatic bit parse_char(input logic [7:0] c, output result_t r);
        logic [3:0] nib;
        bit         hit;
        nib = digit_value(c);
        hit = 1'b0;
        r   = '0;
        if (c == RECORD_MARK) rec_pos = '0;
        case (rec_pos)
            POS_COUNT_HI: part_val = {8'h00, nib, 4'h0};
            POS_COUNT_LO: begin
                part_val  = part_val + nib;
                rec_limit = POS_W'(32'(DATA_START) + 32'(part_val) * 2);
                r   = take_slot(KIND_COUNT);
                hit = 1'b1;
            end
            POS_ADDR_3: part_val = {8'h00, nib, 4'h0};
            POS_ADDR_2: part_val = (part_val + nib) << 8;
            POS_ADDR_1: part_val = part_val + {8'h00, nib, 4'h0};
            POS_ADDR_0: begin
                part_val = part_val + nib;
                r   = take_slot(KIND_ADDR);
                hit = 1'b1;
            end
            default: ;
        endcase
        if (rec_pos >= DATA_START && rec_pos < rec_limit) begin
            case (rec_pos[1:0] & PHASE_MASK)
                PHASE_LO_HI: part_val = {8'h00, nib, 4'h0};
                PHASE_LO_LO: part_val = part_val + nib;
                PHASE_HI_HI: part_high = {8'h00, nib, 4'h0};
                default: begin
                    part_high  = (part_high + nib) << 8;
                    part_val   = part_val + part_high;
                    word_total = word_total + 16'd1;
                    r   = take_slot(KIND_WORD);
                    hit = 1'b1;
                end
            endcase
        end
        if (rec_pos < POS_MAX) rec_pos = rec_pos + 1'b1;
        return hit;
    endfunction

    function automatic hex_char_t row(input logic [7:0] c);
        return '{ch: c, typed: 1'b0, res: '0};
    endfunction

    function automatic hex_char_t row_exp(input logic [7:0] c, input logic [5:0] sl,
                                          input logic [15:0] v, input kind_t k,
                                          input logic [15:0] w);
        hex_char_t h;
        h.ch  = c;
        h.typed = 1'b1;
        h.res.slot = sl;
        h.res.value = v;
        h.res.kind = k;
        h.res.words_seen = w;
        return h;
    endfunction

    task automatic add_char(input logic [7:0] c);
        char_q.push_back(row(c));
    endtask

    // Push hex digits, most significant first; spoil some into lower case or noise
    task automatic add_hex(input int unsigned val, input int digits, input int spoil);
        logic [3:0] nib;
        logic [7:0] c;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = 4'(val >> (4 * i));
            c = (nib < 4'd10) ? CH_ZERO + nib : CH_UPPER_A + (nib - 4'd10);
            if ($urandom_range(0, 99) < spoil) begin
                if (nib >= 4'd10) c = c + (CH_LOWER_A - CH_UPPER_A);
                else c = 8'($urandom_range(0, 255));
            end
            add_char(c);
        end
    endtask

    task automatic add_record();
        int unsigned n, cut, spoil, pick;
        spoil = ($urandom_range(0, 9) == 0) ? 15 : 0;
        pick  = $urandom_range(0, 99);
        if (pick < 2) n = 255;
        else if (pick < 6) n = $urandom_range(17, 254);
        else n = $urandom_range(0, 16);
        // Truncate the data of an occasional record
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2 * n) : 2 * n;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
        end
        add_char(RECORD_MARK);
        records_sent++;
        add_hex(n, 2, spoil);
        add_hex($urandom_range(0, 65535), 4, spoil);
        add_hex(($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0, 2, spoil);
        for (int b = 0; b < cut; b++) add_hex($urandom_range(0, 15), 1, spoil);
        if (cut == 2 * n) begin
            add_hex($urandom_range(0, 255), 2, spoil);
            if ($urandom_range(0, 1) == 1) add_char(CH_CR);
            add_char(CH_LF);
        end
    endtask

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= REPORT_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    function automatic bit idle_now();
        return (cycle_no < CALM_FROM || cycle_no > CALM_TO) &&
               ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Character source: hold valid and payload until the transfer
    always @(posedge aclk) begin
        result_t r;
        bit      hit;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hit = parse_char(on_wire.ch, r);
                if (on_wire.typed) entry_q.push_back(on_wire.res);
                else if (hit) entry_q.push_back(r);
                chars_sent++;
            end
            if (!s_valid || s_ready) begin
                if (char_q.size() != 0 && !idle_now()) begin
                    on_wire = char_q.pop_front();
                    s_valid   <= 1'b1;
                    s_rx_char <= on_wire.ch;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !idle_now();
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (entry_q.size() == 0) begin
                note_fault($sformatf("unexpected entry slot=%0d value=%h kind=%0d words=%0d",
                                     m_slot, m_value, m_kind, m_words_seen));
            end else begin
                want = entry_q.pop_front();
                if (m_slot !== want.slot || m_value !== want.value ||
                    m_kind !== want.kind || m_words_seen !== want.words_seen) begin
                    note_fault($sformatf({"entry mismatch: exp slot=%0d value=%h kind=%0d ",
                                          "words=%0d, got slot=%0d value=%h kind=%0d words=%0d"},
                                         want.slot, want.value, want.kind, want.words_seen,
                                         m_slot, m_value, m_kind, m_words_seen));
                end
                if (m_kind <= 2'd2) kind_seen[m_kind]++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d entries outstanding",
                     cycle_no, entry_q.size());
            $display("** intel_hex_record_word_extractor_top: FAILED **");
            $finish;
        end
    end

    initial begin
        // Characters before the first colon, full-scale count/address/word,
        // then an empty record with lower-case and non-hex characters.
        script = '{
            row(8'hFF), row("1"),
            row_exp("2", 6'd0, 16'h0012, KIND_COUNT, 16'd0),
            row(RECORD_MARK), row("F"),
            row_exp("F", 6'd1, 16'h00FF, KIND_COUNT, 16'd0),
            row("F"), row("F"), row("F"),
            row_exp("F", 6'd2, 16'hFFFF, KIND_ADDR, 16'd0),
            row("0"), row("0"), row("F"), row("F"), row("F"),
            row_exp("F", 6'd3, 16'hFFFF, KIND_WORD, 16'd1),
            row(RECORD_MARK), row("0"), row("a"), row(8'h00), row("0"), row("9"),
            row("g"), row("0"), row("1")
        };
        foreach (script[i]) char_q.push_back(script[i]);
        while (char_q.size() < ITEMS) begin
            add_record();
            // One line long enough to saturate the position counter
            if (filler == 0 && char_q.size() > ITEMS / 4) begin
                repeat (FILLER_LEN) begin
                    logic [7:0] c;
                    c = 8'($urandom_range(0, 255));
                    add_char((c == RECORD_MARK) ? CH_LOWER_A : c);
                end
                filler = FILLER_LEN;
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_q.size() != 0 || s_valid) @(posedge aclk);
        while (entry_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (entry_q.size() != 0) note_fault($sformatf("%0d entries never arrived", entry_q.size()));
        $display("run covered %0d characters in %0d random records plus directed rows",
                 chars_sent, records_sent);
        $display("entries checked: %0d counts, %0d addresses, %0d words; %0d faults",
                 kind_seen[0], kind_seen[1], kind_seen[2], faults);
        if (faults == 0) begin
            $display("** intel_hex_record_word_extractor_top: PASSED **");
        end else begin
            $display("** intel_hex_record_word_extractor_top: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ihex_pkg.sv
rtl/ihex_in_stage.sv
rtl/ihex_parse.sv
rtl/ihex_out_stage.sv
rtl/intel_hex_record_word_extractor_top.sv
tb/tb_intel_hex_record_word_extractor_top.sv
